@@ hw/rtl/scm_pkg.sv @@
package scm_pkg;

    // field widths
    localparam int ANGLE_W = 32;
    localparam int OUT_W   = 32;

    // internal widths
    localparam int Y2_W    = 32;
    localparam int M30_W   = 31;
    localparam int ACC_W   = 34;
    localparam int MAG_W   = ACC_W - 1;
    localparam int YR_W    = 37;
    localparam int N_CELLS = 5;

    // range reduction constants, angles in Q.32
    localparam logic [29:0]             INV_TWO_PI  = 30'd683565276;
    localparam logic signed [35:0]      TWO_PI      = 36'sd26986075409;
    localparam logic signed [YR_W-1:0]  PI_Q32      = 37'sd13493037705;
    localparam logic signed [YR_W-1:0]  HALF_PI_Q32 = 37'sd6746518852;
    localparam logic signed [YR_W-1:0]  NEG_PI_Q32  = -37'sd13493037705;
    localparam logic signed [YR_W-1:0]  NEG_HALF_PI = -37'sd6746518852;

    // plus one in Q2.30, as a magnitude
    localparam logic [MAG_W-1:0] ONE_MAG = 33'd1073741824;

    typedef logic signed [ACC_W-1:0] t_acc;

    // sideband that travels with each transaction down the chain
    typedef struct packed {
        logic             valid;
        logic [Y2_W-1:0]  y2;
        logic [M30_W-1:0] m30;
        logic             yneg;
        logic             flip;
    } t_side;

    // polynomial coefficients, signed Q.32
    localparam t_acc SIN_C0 = -34'sd103;
    localparam t_acc COS_C0 = -34'sd1119;

    localparam t_acc SIN_COEF [N_CELLS] = '{
        34'sd11822, -34'sd852159, 34'sd35791384, -34'sd715827897, 34'sd4294967296
    };
    localparam t_acc COS_COEF [N_CELLS] = '{
        34'sd106346, -34'sd5965013, 34'sd178956848, -34'sd2147483648, 34'sd4294967296
    };

endpackage

@@ hw/rtl/scm_reduce.sv @@
module scm_reduce (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [scm_pkg::ANGLE_W-1:0]  i_angle,
    output scm_pkg::t_side                      o_side
);
    import scm_pkg::*;

    localparam int PROD1_W = ANGLE_W + 30;
    localparam int Q_SH    = 56;
    localparam int QM_W    = 5;
    localparam int Q_W     = QM_W + 1;
    localparam int Y_W     = 42;
    localparam int SQ_W    = 2 * M30_W;
    localparam int Y2_SH   = 30;

    // stage registers
    logic                       r1_valid, r2_valid, r3_valid, r4_valid;
    logic                       r5_valid, r6_valid, r7_valid;
    logic                       r1_neg;
    logic signed [ANGLE_W-1:0]  r1_angle, r2_angle;
    logic [PROD1_W-1:0]         r1_prod;
    logic signed [Q_W-1:0]      r2_q;
    logic signed [YR_W-1:0]     r3_y, r4_y;
    logic                       r4_flip, r5_flip, r6_flip, r7_flip;
    logic                       r5_yneg, r6_yneg, r7_yneg;
    logic [M30_W-1:0]           r5_m30, r6_m30, r7_m30;
    logic [SQ_W-1:0]            r6_sq;
    logic [Y2_W-1:0]            r7_y2;

    // next values
    logic [ANGLE_W-1:0]         ua;
    logic [PROD1_W-1:0]         n1_prod;
    logic [PROD1_W:0]           sum2;
    logic [QM_W-1:0]            qmag;
    logic signed [Q_W-1:0]      n2_q;
    logic signed [Y_W-1:0]      y_full;
    logic signed [YR_W-1:0]     n4_y;
    logic                       n4_flip;
    logic [YR_W-1:0]            ymag;
    logic [M30_W-1:0]           n5_m30;
    logic [SQ_W-1:0]            n6_sq;
    logic [SQ_W:0]              sum7;

    // whole turns: |angle| times 1/(2*pi)
    assign ua      = i_angle[ANGLE_W-1] ? ANGLE_W'(-i_angle) : ANGLE_W'(i_angle);
    assign n1_prod = PROD1_W'(ua) * PROD1_W'(INV_TWO_PI);

    // round the turn count half away from zero and apply the sign
    assign sum2 = {1'b0, r1_prod} + ((PROD1_W + 1)'(1) << (Q_SH - 1));
    assign qmag = sum2[Q_SH +: QM_W];
    assign n2_q = r1_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

    // subtract the turns, angle moved to Q.32
    assign y_full = (Y_W'(r2_angle) <<< 8) - Y_W'(r2_q) * Y_W'(TWO_PI);

    // fold into [-pi/2, pi/2]
    always_comb begin
        n4_y    = r3_y;
        n4_flip = 1'b0;
        if (r3_y > HALF_PI_Q32) begin
            n4_y    = PI_Q32 - r3_y;
            n4_flip = 1'b1;
        end else if (r3_y < NEG_HALF_PI) begin
            n4_y    = NEG_PI_Q32 - r3_y;
            n4_flip = 1'b1;
        end
    end

    // magnitude rounded to Q.30
    assign ymag   = r4_y[YR_W-1] ? YR_W'(-r4_y) : YR_W'(r4_y);
    assign n5_m30 = M30_W'((ymag + YR_W'(2)) >> 2);

    // square and round to Q.30
    assign n6_sq = SQ_W'(r5_m30) * SQ_W'(r5_m30);
    assign sum7  = {1'b0, r6_sq} + ((SQ_W + 1)'(1) << (Y2_SH - 1));

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg   <= i_angle[ANGLE_W-1];
            r1_angle <= i_angle;
            r1_prod  <= n1_prod;
            r2_angle <= r1_angle;
            r2_q     <= n2_q;
            r3_y     <= YR_W'(y_full);
            r4_y     <= n4_y;
            r4_flip  <= n4_flip;
            r5_m30   <= n5_m30;
            r5_yneg  <= r4_y[YR_W-1];
            r5_flip  <= r4_flip;
            r6_sq    <= n6_sq;
            r6_m30   <= r5_m30;
            r6_yneg  <= r5_yneg;
            r6_flip  <= r5_flip;
            r7_y2    <= sum7[Y2_SH +: Y2_W];
            r7_m30   <= r6_m30;
            r7_yneg  <= r6_yneg;
            r7_flip  <= r6_flip;
        end
    end

    assign o_side.valid = r7_valid;
    assign o_side.y2    = r7_y2;
    assign o_side.m30   = r7_m30;
    assign o_side.yneg  = r7_yneg;
    assign o_side.flip  = r7_flip;

endmodule

@@ hw/rtl/scm_cell.sv @@
module scm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  scm_pkg::t_side  i_side,
    input  scm_pkg::t_acc   i_acc_sin,
    input  scm_pkg::t_acc   i_acc_cos,
    input  scm_pkg::t_acc   i_coef_sin,
    input  scm_pkg::t_acc   i_coef_cos,
    output scm_pkg::t_side  o_side,
    output scm_pkg::t_acc   o_acc_sin,
    output scm_pkg::t_acc   o_acc_cos
);
    import scm_pkg::*;

    localparam int PROD_W = MAG_W + Y2_W;
    localparam int RND_SH = 30;
    localparam int SUM_W  = ACC_W + 2;

    t_side                  r_side_a, r_side_b;
    logic [PROD_W-1:0]      r_prod_sin, r_prod_cos;
    logic                   r_neg_sin, r_neg_cos;
    t_acc                   r_acc_sin, r_acc_cos;

    logic [MAG_W-1:0]       mag_sin, mag_cos;
    logic [PROD_W-1:0]      n_prod_sin, n_prod_cos;
    logic [PROD_W:0]        sum_sin, sum_cos;
    logic signed [SUM_W-1:0] rnd_sin, rnd_cos;
    logic signed [SUM_W-1:0] coef_sin, coef_cos;
    logic signed [SUM_W-1:0] n_acc_sin, n_acc_cos;

    // first half: magnitude of the accumulator times y squared
    assign mag_sin    = i_acc_sin[ACC_W-1] ? MAG_W'(-i_acc_sin) : MAG_W'(i_acc_sin);
    assign mag_cos    = i_acc_cos[ACC_W-1] ? MAG_W'(-i_acc_cos) : MAG_W'(i_acc_cos);
    assign n_prod_sin = PROD_W'(mag_sin) * PROD_W'(i_side.y2);
    assign n_prod_cos = PROD_W'(mag_cos) * PROD_W'(i_side.y2);

    // second half: round to Q.32, restore the sign and add the coefficient
    assign sum_sin  = {1'b0, r_prod_sin} + ((PROD_W + 1)'(1) << (RND_SH - 1));
    assign sum_cos  = {1'b0, r_prod_cos} + ((PROD_W + 1)'(1) << (RND_SH - 1));
    assign rnd_sin  = $signed(SUM_W'(sum_sin >> RND_SH));
    assign rnd_cos  = $signed(SUM_W'(sum_cos >> RND_SH));
    assign coef_sin = SUM_W'(i_coef_sin);
    assign coef_cos = SUM_W'(i_coef_cos);
    assign n_acc_sin = r_neg_sin ? coef_sin - rnd_sin : coef_sin + rnd_sin;
    assign n_acc_cos = r_neg_cos ? coef_cos - rnd_cos : coef_cos + rnd_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_a.valid <= 1'b0;
            r_side_b.valid <= 1'b0;
        end else if (i_en) begin
            r_side_a   <= i_side;
            r_prod_sin <= n_prod_sin;
            r_prod_cos <= n_prod_cos;
            r_neg_sin  <= i_acc_sin[ACC_W-1];
            r_neg_cos  <= i_acc_cos[ACC_W-1];
            r_side_b   <= r_side_a;
            r_acc_sin  <= ACC_W'(n_acc_sin);
            r_acc_cos  <= ACC_W'(n_acc_cos);
        end
    end

    assign o_side    = r_side_b;
    assign o_acc_sin = r_acc_sin;
    assign o_acc_cos = r_acc_cos;

endmodule

@@ hw/rtl/scm_finish.sv @@
module scm_finish (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  scm_pkg::t_side                     i_side,
    input  scm_pkg::t_acc                      i_ps,
    input  scm_pkg::t_acc                      i_pc,
    input  logic                               i_out_stall,
    output logic                               o_adv,
    output logic                               o_out_valid,
    output logic signed [scm_pkg::OUT_W-1:0]   o_sine_value,
    output logic signed [scm_pkg::OUT_W-1:0]   o_cosine_value
);
    import scm_pkg::*;

    localparam int FP_W   = MAG_W + M30_W;
    localparam int SIN_SH = 32;

    logic                       adv;

    // pipeline registers
    logic                       r_f1_valid, r_res_valid;
    logic [FP_W-1:0]            r_fp;
    logic                       r_sneg, r_cneg;
    logic [MAG_W-1:0]           r_cm;
    logic signed [OUT_W-1:0]    r_res_sin, r_res_cos;

    // output register and skid stage
    logic                       r_out_valid, r_skid_valid;
    logic signed [OUT_W-1:0]    r_out_sin, r_out_cos, r_skid_sin, r_skid_cos;

    logic [MAG_W-1:0]           mag_ps, n_cm;
    logic [FP_W-1:0]            n_fp;
    logic [FP_W:0]              sum_s;
    logic [MAG_W-1:0]           smag, cmag, s_sat, c_sat;
    logic [MAG_W:0]             sum_c;
    logic signed [OUT_W-1:0]    n_res_sin, n_res_cos;

    assign adv = !r_skid_valid;

    // sine: sine sum times |y|; cosine: magnitude and fold sign
    assign mag_ps = i_ps[ACC_W-1] ? MAG_W'(-i_ps) : MAG_W'(i_ps);
    assign n_cm   = i_pc[ACC_W-1] ? MAG_W'(-i_pc) : MAG_W'(i_pc);
    assign n_fp   = FP_W'(mag_ps) * FP_W'(i_side.m30);

    // round, saturate to plus or minus one and apply the signs
    assign sum_s = {1'b0, r_fp} + ((FP_W + 1)'(1) << (SIN_SH - 1));
    assign smag  = MAG_W'(sum_s >> SIN_SH);
    assign sum_c = {1'b0, r_cm} + (MAG_W + 1)'(2);
    assign cmag  = MAG_W'(sum_c >> 2);
    assign s_sat = (smag > ONE_MAG) ? ONE_MAG : smag;
    assign c_sat = (cmag > ONE_MAG) ? ONE_MAG : cmag;
    assign n_res_sin = r_sneg ? -$signed(OUT_W'(s_sat)) : $signed(OUT_W'(s_sat));
    assign n_res_cos = r_cneg ? -$signed(OUT_W'(c_sat)) : $signed(OUT_W'(c_sat));

    // last two pipeline stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (adv) begin
            r_f1_valid  <= i_side.valid;
            r_fp        <= n_fp;
            r_sneg      <= i_ps[ACC_W-1] ^ i_side.yneg;
            r_cm        <= n_cm;
            r_cneg      <= i_pc[ACC_W-1] ^ i_side.flip;
            r_res_valid <= r_f1_valid;
            r_res_sin   <= n_res_sin;
            r_res_cos   <= n_res_cos;
        end
    end

    // output register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_sin    <= r_skid_sin;
                r_out_cos    <= r_skid_cos;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= r_res_valid;
                r_out_sin    <= r_res_sin;
                r_out_cos    <= r_res_cos;
            end
        end else if (adv && r_res_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_sin   <= r_res_sin;
            r_skid_cos   <= r_res_cos;
        end
    end

    assign o_adv          = adv;
    assign o_out_valid    = r_out_valid;
    assign o_sine_value   = r_out_sin;
    assign o_cosine_value = r_out_cos;

endmodule

@@ hw/rtl/sine_cosine_minimax.sv @@
// channel  | handshake                  | payload
// input    | i_in_valid / o_in_stall    | i_angle (Q8.24)
// output   | o_out_valid / i_out_stall  | o_sine_value, o_cosine_value (Q2.30)
//
// one angle per cycle while o_in_stall is low; a result passes seven
// reduction stages, five two-stage horner cells and two finishing stages
// before it reaches the output register
// reset clears only the valid bits; no clearing pass is needed
// a stalled output parks one result in a skid stage, after which the whole
// chain holds and o_in_stall rises until the skid stage drains
module sine_cosine_minimax (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [scm_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [scm_pkg::OUT_W-1:0]   o_sine_value,
    output logic signed [scm_pkg::OUT_W-1:0]   o_cosine_value
);
    import scm_pkg::*;

    logic  adv;
    t_side side_c  [N_CELLS+1];
    t_acc  acc_sin [N_CELLS+1];
    t_acc  acc_cos [N_CELLS+1];

    // range reduction and y squared
    scm_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_angle (i_angle),
        .o_side  (side_c[0])
    );

    assign acc_sin[0] = SIN_C0;
    assign acc_cos[0] = COS_C0;

    // horner chain, one coefficient pair per cell
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        scm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (adv),
            .i_side     (side_c[g]),
            .i_acc_sin  (acc_sin[g]),
            .i_acc_cos  (acc_cos[g]),
            .i_coef_sin (SIN_COEF[g]),
            .i_coef_cos (COS_COEF[g]),
            .o_side     (side_c[g+1]),
            .o_acc_sin  (acc_sin[g+1]),
            .o_acc_cos  (acc_cos[g+1])
        );
    end

    // final product, rounding, saturation and output
    scm_finish u_finish (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_side         (side_c[N_CELLS]),
        .i_ps           (acc_sin[N_CELLS]),
        .i_pc           (acc_cos[N_CELLS]),
        .i_out_stall    (i_out_stall),
        .o_adv          (adv),
        .o_out_valid    (o_out_valid),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

    assign o_in_stall = !adv;

endmodule

@@ dv/tb_sine_cosine_minimax.sv @@
module tb_sine_cosine_minimax;

    // fixed-point constants, radians in Q.32 and coefficients in signed Q.32
    localparam longint unsigned INV_TURN = 64'd683565276;
    localparam longint TURN_Q32    = 64'sd26986075409;
    localparam longint HALF_TURN   = 64'sd13493037705;
    localparam longint QUARTER     = 64'sd6746518852;
    localparam longint UNIT_Q30    = 64'sd1073741824;
    localparam longint UNIT_Q32    = 64'sd4294967296;
    localparam longint SIN_TAPS [5] = '{
        -64'sd103, 64'sd11822, -64'sd852159, 64'sd35791384, -64'sd715827897
    };
    localparam longint COS_TAPS [5] = '{
        -64'sd1119, 64'sd106346, -64'sd5965013, 64'sd178956848, -64'sd2147483648
    };

    // angle steps in Q8.24
    localparam int PI_Q24      = 52707179;
    localparam int HALF_PI_Q24 = 26353589;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int DRAIN_LIMIT = 4000;
    localparam int RUN_LIMIT   = 4 * 250000;

    typedef struct {
        logic signed [scm_pkg::ANGLE_W-1:0] angle;
        logic signed [scm_pkg::OUT_W-1:0]   sine;
        logic signed [scm_pkg::OUT_W-1:0]   cosine;
    } sincos_t;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [scm_pkg::ANGLE_W-1:0] i_angle;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [scm_pkg::OUT_W-1:0]   o_sine_value;
    logic signed [scm_pkg::OUT_W-1:0]   o_cosine_value;

    sincos_t pending_sincos [$];
    int      n_sent;
    int      n_checked;
    int      n_errors;
    bit      send_gaps;
    bit      rx_gaps;
    bit      hold_req;

    sine_cosine_minimax u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_angle        (i_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // round(a * b / 2^sh) on the magnitude, half away from zero
    function automatic longint round_scaled(input longint a, input longint unsigned b,
                                            input int sh);
        longint unsigned mag;
        longint unsigned r;
        mag = (a < 0) ? -a : a;
        r = (mag * b + (64'd1 << (sh - 1))) >> sh;
        return (a < 0) ? -$signed(r) : $signed(r);
    endfunction

    // horner in y squared, with the trailing plus one
    function automatic longint poly_in_y2(input bit is_cos, input longint unsigned y2);
        longint acc;
        acc = is_cos ? COS_TAPS[0] : SIN_TAPS[0];
        for (int i = 1; i < 5; i++)
            acc = round_scaled(acc, y2, 30) + (is_cos ? COS_TAPS[i] : SIN_TAPS[i]);
        return round_scaled(acc, y2, 30) + UNIT_Q32;
    endfunction

    function automatic logic signed [scm_pkg::OUT_W-1:0] clamp_unit(input longint v);
        if (v > UNIT_Q30)
            return 32'(UNIT_Q30);
        if (v < -UNIT_Q30)
            return 32'(-UNIT_Q30);
        return 32'(v);
    endfunction

    // expected sine and cosine of one angle
    function automatic sincos_t compute_sincos(input logic signed [scm_pkg::ANGLE_W-1:0] ang);
        sincos_t         res;
        longint          a;
        longint          turns;
        longint          y;
        longint          psum;
        longint          csum;
        longint          s;
        longint          c;
        longint unsigned ua;
        longint unsigned m;
        longint unsigned m30;
        longint unsigned y2;
        longint unsigned cmag;
        bit              flip;
        bit              yneg;
        a = ang;
        ua = (a < 0) ? -a : a;
        turns = $signed((ua * INV_TURN + (64'd1 << 55)) >> 56);
        if (a < 0)
            turns = -turns;
        y = a * 256 - turns * TURN_Q32;
        // fold into the right half plane, flipping the cosine
        flip = 1'b0;
        if (y > QUARTER) begin
            y = HALF_TURN - y;
            flip = 1'b1;
        end else if (y < -QUARTER) begin
            y = -HALF_TURN - y;
            flip = 1'b1;
        end
        yneg = (y < 0);
        m = yneg ? -y : y;
        m30 = (m + 64'd2) >> 2;
        y2 = (m30 * m30 + (64'd1 << 29)) >> 30;
        psum = poly_in_y2(1'b0, y2);
        csum = poly_in_y2(1'b1, y2);
        s = round_scaled(psum, m30, 32);
        if (yneg)
            s = -s;
        cmag = (csum < 0) ? -csum : csum;
        c = $signed((cmag + 64'd2) >> 2);
        if ((csum < 0) != flip)
            c = -c;
        res.angle  = ang;
        res.sine   = clamp_unit(s);
        res.cosine = clamp_unit(c);
        return res;
    endfunction

    task automatic report_failure(input string msg);
        n_errors++;
        if (n_errors <= 50)
            $display("ERROR: %s", msg);
    endtask

    // offer one angle, with an optional idle burst first, until it is taken
    task automatic drive_angle(input logic signed [scm_pkg::ANGLE_W-1:0] ang);
        @(negedge i_clk);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            i_angle    <= $urandom();
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_angle    <= ang;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_sincos.push_back(compute_sincos(ang));
        n_sent++;
    endtask

    // receiver: long hold-off on request, otherwise random stall bursts
    initial begin
        int hold_count;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        sincos_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_sincos.size() == 0) begin
                report_failure($sformatf("unexpected result sin %0d cos %0d",
                                         o_sine_value, o_cosine_value));
            end else begin
                want = pending_sincos.pop_front();
                n_checked++;
                if (o_sine_value !== want.sine)
                    report_failure($sformatf("angle %0d: sine expected %0d, got %0d",
                                             want.angle, want.sine, o_sine_value));
                if (o_cosine_value !== want.cosine)
                    report_failure($sformatf("angle %0d: cosine expected %0d, got %0d",
                                             want.angle, want.cosine, o_cosine_value));
            end
        end
    end

    // extremes, quadrant boundaries and near half-turn ties
    task automatic test_directed_angles();
        logic signed [31:0] pts [22] = '{
            32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
            32'sh55555555, 32'shAAAAAAAA,
            HALF_PI_Q24, HALF_PI_Q24 + 1, HALF_PI_Q24 - 1, -HALF_PI_Q24, -HALF_PI_Q24 - 1,
            PI_Q24, PI_Q24 + 1, -PI_Q24, -PI_Q24 - 1,
            3 * PI_Q24, -3 * PI_Q24, 39 * PI_Q24, -39 * PI_Q24,
            2 * PI_Q24, 32'sd16777216
        };
        foreach (pts[i])
            drive_angle(pts[i]);
    endtask

    task automatic test_full_range(input int n);
        repeat (n)
            drive_angle($urandom());
    endtask

    // angles within a couple of turns of zero
    task automatic test_principal_range(input int n);
        longint v;
        repeat (n) begin
            v = longint'($urandom_range(0, 421657428)) - 210828714;
            drive_angle(32'(v));
        end
    endtask

    // multiples of pi/2 with a small offset, where the fold decisions sit
    task automatic test_quadrant_edges(input int n);
        longint k;
        longint v;
        repeat (n) begin
            k = longint'($urandom_range(0, 162)) - 81;
            v = k * HALF_PI_Q24 + longint'($urandom_range(0, 64)) - 32;
            drive_angle(32'(v));
        end
    endtask

    // output held off while angles keep coming, so the chain fills and stalls
    task automatic test_output_holdoff(input int n);
        send_gaps = 1'b0;
        hold_req  = 1'b1;
        repeat (n)
            drive_angle($urandom());
        send_gaps = 1'b1;
    endtask

    // back-to-back transactions with no idling on either side
    task automatic test_gapless_stream(input int n);
        send_gaps = 1'b0;
        rx_gaps   = 1'b0;
        repeat (n) begin
            if ($urandom_range(0, 1) == 0)
                drive_angle($urandom());
            else
                drive_angle(32'(longint'($urandom_range(0, 421657428)) - 210828714));
        end
    endtask

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", pending_sincos.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_angle    = '0;
        send_gaps  = 1'b1;
        rx_gaps    = 1'b1;
        hold_req   = 1'b0;
        n_sent     = 0;
        n_checked  = 0;
        n_errors   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_angles();
        test_full_range(400);
        test_principal_range(300);
        test_quadrant_edges(150);
        test_output_holdoff(120);
        test_gapless_stream(150);

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain, then watch for stray results
        waited = 0;
        while (pending_sincos.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_sincos.size() != 0)
            report_failure($sformatf("%0d results never arrived", pending_sincos.size()));

        $display("covered %0d angles: extremes, quadrant edges, near half turns, full range",
                 n_sent);
        $display("checked %0d results, including a %0d-cycle output hold-off and a gap-free run",
                 n_checked, HOLD_CYCLES);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
